>>> src/prs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Prime stepper package
// Word types, command codes, control word layout and the microcode table.
// -----------------------------------------------------------------------------
package prs_pkg;

   localparam int PRS_VALUE_WIDTH = 16;
   localparam int FIELD_W         = 16;

   localparam logic [1:0] CMD_REPORT = 2'd0;
   localparam logic [1:0] CMD_LOAD   = 2'd1;
   localparam logic [1:0] CMD_UP     = 2'd2;
   localparam logic [1:0] CMD_DOWN   = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic [FIELD_W-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] old_value;
      logic [FIELD_W-1:0] new_value;
      logic               overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_FETCH,
      OP_SET_UP,
      OP_SET_DOWN,
      OP_STEP,
      OP_INIT_DIV,
      OP_REM_START,
      OP_NEXT_DIV,
      OP_LOAD,
      OP_SET_ONE,
      OP_COMMIT,
      OP_SET_OVF,
      OP_POST
   } dp_op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_REPORT,
      C_LOAD,
      C_UP,
      C_CAND_LE2,
      C_CAND_EQ2,
      C_CAND_LT2,
      C_SQ_GT,
      C_REM_BUSY,
      C_REM_ZERO,
      C_CAND_MAX,
      C_OUT_BUSY
   } cond_type;

   localparam int UCODE_DEPTH = 23;
   localparam int UADDR_W     = 5;

   typedef logic [UADDR_W-1:0] uaddr_type;

   localparam uaddr_type UA_WAIT     = 5'd0;
   localparam uaddr_type UA_DOWN     = 5'd4;
   localparam uaddr_type UA_NEXT     = 5'd5;
   localparam uaddr_type UA_TLOOP    = 5'd8;
   localparam uaddr_type UA_REM_WAIT = 5'd10;
   localparam uaddr_type UA_NOTPRIME = 5'd13;
   localparam uaddr_type UA_UP       = 5'd15;
   localparam uaddr_type UA_LOAD     = 5'd17;
   localparam uaddr_type UA_ONE      = 5'd18;
   localparam uaddr_type UA_COMMIT   = 5'd19;
   localparam uaddr_type UA_OVF      = 5'd20;
   localparam uaddr_type UA_DONE     = 5'd21;
   localparam uaddr_type UA_RET      = 5'd22;

   typedef struct packed {
      dp_op_type op;
      cond_type  cond;
      uaddr_type target;
   } ctrl_word_type;

   // Status flags that the datapath returns to the sequencer.
   typedef struct packed {
      logic no_req;
      logic cmd_report;
      logic cmd_load;
      logic cmd_up;
      logic cand_le2;
      logic cand_eq2;
      logic cand_lt2;
      logic sq_gt;
      logic rem_busy;
      logic rem_zero;
      logic cand_max;
      logic out_busy;
   } status_type;

   function automatic ctrl_word_type uw(input dp_op_type op, input cond_type cond,
                                        input uaddr_type target);
      ctrl_word_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // The program. A step jumps to its target when its condition holds and
   // otherwise falls through to the next step. The operation always executes.
   function automatic ctrl_word_type prs_ucode(input uaddr_type addr);
      ctrl_word_type w;
      unique case (addr)
         5'd0:    w = uw(OP_FETCH,     C_NO_REQ,   UA_WAIT);
         5'd1:    w = uw(OP_NOP,       C_REPORT,   UA_DONE);
         5'd2:    w = uw(OP_NOP,       C_LOAD,     UA_LOAD);
         5'd3:    w = uw(OP_NOP,       C_UP,       UA_UP);
         5'd4:    w = uw(OP_SET_DOWN,  C_CAND_LE2, UA_ONE);
         5'd5:    w = uw(OP_STEP,      C_NEVER,    UA_WAIT);
         5'd6:    w = uw(OP_INIT_DIV,  C_CAND_EQ2, UA_COMMIT);
         5'd7:    w = uw(OP_NOP,       C_CAND_LT2, UA_NOTPRIME);
         5'd8:    w = uw(OP_NOP,       C_SQ_GT,    UA_COMMIT);
         5'd9:    w = uw(OP_REM_START, C_NEVER,    UA_WAIT);
         5'd10:   w = uw(OP_NOP,       C_REM_BUSY, UA_REM_WAIT);
         5'd11:   w = uw(OP_NEXT_DIV,  C_REM_ZERO, UA_NOTPRIME);
         5'd12:   w = uw(OP_NOP,       C_ALWAYS,   UA_TLOOP);
         5'd13:   w = uw(OP_NOP,       C_CAND_MAX, UA_OVF);
         5'd14:   w = uw(OP_NOP,       C_ALWAYS,   UA_NEXT);
         5'd15:   w = uw(OP_SET_UP,    C_CAND_MAX, UA_OVF);
         5'd16:   w = uw(OP_NOP,       C_ALWAYS,   UA_NEXT);
         5'd17:   w = uw(OP_LOAD,      C_ALWAYS,   UA_DONE);
         5'd18:   w = uw(OP_SET_ONE,   C_ALWAYS,   UA_DONE);
         5'd19:   w = uw(OP_COMMIT,    C_ALWAYS,   UA_DONE);
         5'd20:   w = uw(OP_SET_OVF,   C_NEVER,    UA_WAIT);
         5'd21:   w = uw(OP_POST,      C_OUT_BUSY, UA_DONE);
         5'd22:   w = uw(OP_NOP,       C_ALWAYS,   UA_WAIT);
         default: w = uw(OP_NOP,       C_ALWAYS,   UA_WAIT);
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

>>> src/prs_rem_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Prime stepper remainder unit
// Restoring division, one quotient bit per cycle; only the remainder is kept.
// -----------------------------------------------------------------------------
module prs_rem_unit
   import prs_pkg::*;
#(
   parameter int VALUE_WIDTH = PRS_VALUE_WIDTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [VALUE_WIDTH-1:0] dividend,
   input  wire logic [VALUE_WIDTH-1:0] divisor,
   output logic                        busy,
   output logic                        rem_zero
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH:0]   trial;

   assign busy     = (count_ff != '0);
   assign rem_zero = (rem_ff == '0);
   assign trial    = {rem_ff, shift_ff[VALUE_WIDTH-1]};

   always_comb begin
      count_in = count_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         count_in = CNT_W'(VALUE_WIDTH);
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (busy) begin
         count_in = count_ff - 1'b1;
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         // The partial remainder stays below the divisor, so it fits the width.
         if (trial >= {1'b0, div_ff}) begin
            rem_in = VALUE_WIDTH'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[VALUE_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rem_ff < div_ff)
      else $error("remainder not below divisor at end of division");

endmodule
`default_nettype wire

>>> src/prs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Prime stepper datapath
// Current value, candidate, trial divisor and its square, result register.
// -----------------------------------------------------------------------------
module prs_datapath
   import prs_pkg::*;
#(
   parameter int VALUE_WIDTH = PRS_VALUE_WIDTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_word_type ctrl,
   output status_type         status,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire req_type       req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output rsp_type            rsp_data
);

   localparam int W = VALUE_WIDTH;
   localparam logic [W-1:0] ONE = W'(1);
   localparam logic [W-1:0] TWO = W'(2);
   localparam logic [W:0]   FOUR = (W + 1)'(4);

   logic [W-1:0] cur_ff, cur_in;
   logic [W-1:0] old_ff, old_in;
   logic [W-1:0] cand_ff, cand_in;
   logic [W-1:0] div_ff, div_in;
   logic [W:0]   sq_ff, sq_in;
   logic         up_ff, up_in;
   logic         ovf_ff, ovf_in;
   logic [1:0]   cmd_ff, cmd_in;
   logic [W-1:0] load_ff, load_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   logic [W-1:0]       load_fit;
   logic [FIELD_W-1:0] old_fit;
   logic [FIELD_W-1:0] cur_fit;
   logic               rem_start;
   logic               rem_busy;
   logic               rem_zero;
   logic               out_busy;

   generate
      if (W >= FIELD_W) begin : g_wide
         assign load_fit = W'(req_data.load_value);
         assign old_fit  = old_ff[FIELD_W-1:0];
         assign cur_fit  = cur_ff[FIELD_W-1:0];
      end else begin : g_narrow
         assign load_fit = req_data.load_value[W-1:0];
         assign old_fit  = {{(FIELD_W - W){1'b0}}, old_ff};
         assign cur_fit  = {{(FIELD_W - W){1'b0}}, cur_ff};
      end
   endgenerate

   prs_rem_unit #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (cand_ff),
      .divisor  (div_ff),
      .busy     (rem_busy),
      .rem_zero (rem_zero)
   );

   assign out_busy  = rsp_valid_ff && rsp_stall;
   // No word is taken while reset is held.
   assign req_stall = reset || (ctrl.op != OP_FETCH);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      status.no_req     = !req_valid;
      status.cmd_report = (cmd_ff == CMD_REPORT);
      status.cmd_load   = (cmd_ff == CMD_LOAD);
      status.cmd_up     = (cmd_ff == CMD_UP);
      status.cand_le2   = (cand_ff <= TWO);
      status.cand_eq2   = (cand_ff == TWO);
      status.cand_lt2   = (cand_ff < TWO);
      status.sq_gt      = (sq_ff > {1'b0, cand_ff});
      status.rem_busy   = rem_busy;
      status.rem_zero   = rem_zero;
      status.cand_max   = &cand_ff;
      status.out_busy   = out_busy;
   end

   always_comb begin
      cur_in       = cur_ff;
      old_in       = old_ff;
      cand_in      = cand_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      up_in        = up_ff;
      ovf_in       = ovf_ff;
      cmd_in       = cmd_ff;
      load_in      = load_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rem_start    = 1'b0;
      unique case (ctrl.op)
         OP_FETCH: begin
            if (req_valid) begin
               cmd_in  = req_data.command;
               load_in = load_fit;
               old_in  = cur_ff;
               cand_in = cur_ff;
               ovf_in  = 1'b0;
            end
         end
         OP_SET_UP:    up_in = 1'b1;
         OP_SET_DOWN:  up_in = 1'b0;
         OP_STEP:      cand_in = up_ff ? cand_ff + 1'b1 : cand_ff - 1'b1;
         OP_INIT_DIV: begin
            div_in = TWO;
            sq_in  = FOUR;
         end
         OP_REM_START: rem_start = 1'b1;
         OP_NEXT_DIV: begin
            // (d+1)^2 = d^2 + 2d + 1
            div_in = div_ff + 1'b1;
            sq_in  = sq_ff + {div_ff, 1'b1};
         end
         OP_LOAD:      cur_in = load_ff;
         OP_SET_ONE:   cur_in = ONE;
         OP_COMMIT:    cur_in = cand_ff;
         OP_SET_OVF:   ovf_in = 1'b1;
         OP_POST: begin
            if (!out_busy) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.old_value = old_fit;
               rsp_data_in.new_value = cur_fit;
               rsp_data_in.overflow  = ovf_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= ONE;
         rsp_valid_ff <= 1'b0;
         up_ff        <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
         up_ff        <= up_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      old_ff      <= old_in;
      cand_ff     <= cand_in;
      div_ff      <= div_in;
      sq_ff       <= sq_in;
      cmd_ff      <= cmd_in;
      load_ff     <= load_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_ovf_keeps_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.overflow |-> rsp_data_ff.new_value == rsp_data_ff.old_value)
      else $error("overflow word changed the value");

   a_commit_at_least_two: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == OP_COMMIT |-> cand_ff >= TWO)
      else $error("committed candidate below two");

endmodule
`default_nettype wire

>>> src/prs_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Prime stepper sequencer
// Step counter over the microcode table with conditional jumps.
// -----------------------------------------------------------------------------
module prs_sequencer
   import prs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   output ctrl_word_type   ctrl
);

   uaddr_type upc_ff, upc_in;
   logic      take;

   assign ctrl = prs_ucode(upc_ff);

   always_comb begin
      unique case (ctrl.cond)
         C_NEVER:    take = 1'b0;
         C_ALWAYS:   take = 1'b1;
         C_NO_REQ:   take = status.no_req;
         C_REPORT:   take = status.cmd_report;
         C_LOAD:     take = status.cmd_load;
         C_UP:       take = status.cmd_up;
         C_CAND_LE2: take = status.cand_le2;
         C_CAND_EQ2: take = status.cand_eq2;
         C_CAND_LT2: take = status.cand_lt2;
         C_SQ_GT:    take = status.sq_gt;
         C_REM_BUSY: take = status.rem_busy;
         C_REM_ZERO: take = status.rem_zero;
         C_CAND_MAX: take = status.cand_max;
         C_OUT_BUSY: take = status.out_busy;
         default:    take = 1'b1;
      endcase
      upc_in = take ? ctrl.target : upc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UA_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

   a_upc_in_program: assert property (@(posedge clock) disable iff (reset)
      upc_ff < uaddr_type'(UCODE_DEPTH))
      else $error("step counter left the program");

endmodule
`default_nettype wire

>>> src/prime_stepper_core.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Prime stepper core
// Holds a value and loads, reports or steps it to the next or previous prime (1 when none lies below).
// -----------------------------------------------------------------------------
// Usage: one command word enters on req_* and one result word leaves on rsp_*.
// A word moves when valid is high and stall is low. Each result carries the
// value before and after the command and an overflow flag, which is set when
// no larger prime fits in VALUE_WIDTH bits (the value then stays).
// Sequence: a report goes from dispatch straight to the posting step, a load
// through the load step first. A prime step runs the trial-division loop:
// every candidate is divided by each trial divisor in the bit-serial
// remainder unit; divisors run from 2 up to the square root.
// Throughput: one command at a time; the next command is taken once the
// previous result has been written into the output register.
// Reset: the value becomes 1, no result is pending and the input stalls.
// A stalled result holds in the output register; a new command may be taken
// meanwhile, and its result waits until the register frees up.
// -----------------------------------------------------------------------------
module prime_stepper_core
   import prs_pkg::*;
#(
   parameter int VALUE_WIDTH = PRS_VALUE_WIDTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   ctrl_word_type ctrl;
   status_type    status;

   prs_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   prs_datapath #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
